// File: src/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// Depends on nothing; bbc_front, bbc_back and the top level import it.
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_CURLY  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } in_t;

    typedef struct packed {
        logic done_res;
        logic balanced;
        logic error_so_far;
    } out_t;

    // Classified request: what the stack engine has to do.
    typedef struct packed {
        logic  is_open;
        logic  is_close;
        kind_t kind;
        logic  last;
    } op_t;

    // Front-to-back channel.
    typedef struct packed {
        logic valid;
        op_t  op;
    } op_chan_t;

endpackage

// File: src/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bbc_front.sv
// Front end: accepts characters, classifies them and holds them in a
// two-entry queue toward the stack engine. Depends on bbc_pkg.
`timescale 1ns / 1ps

module bbc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bbc_pkg::in_t     item,
    output logic             full,
    output bbc_pkg::op_chan_t op_chan,
    input  logic             op_ready
);

    import bbc_pkg::*;

    op_t        q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_en, rd_en;
    op_t        op_new;

    // Decode the character into an open/close request with its kind.
    always_comb
    begin
        op_new.is_open  = 1'b0;
        op_new.is_close = 1'b0;
        op_new.kind     = KIND_NONE;
        op_new.last     = item.last_char;
        case (item.character)
            CH_OPEN_ROUND:   begin op_new.is_open  = 1'b1; op_new.kind = KIND_ROUND;  end
            CH_OPEN_SQUARE:  begin op_new.is_open  = 1'b1; op_new.kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin op_new.is_open  = 1'b1; op_new.kind = KIND_CURLY;  end
            CH_CLOSE_ROUND:  begin op_new.is_close = 1'b1; op_new.kind = KIND_ROUND;  end
            CH_CLOSE_SQUARE: begin op_new.is_close = 1'b1; op_new.kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin op_new.is_close = 1'b1; op_new.kind = KIND_CURLY;  end
            default:         op_new.kind = KIND_NONE;
        endcase
    end

    assign full          = (cnt_reg == 2'd2);
    assign wr_en         = push && !full;
    assign op_chan.valid = (cnt_reg != 2'd0);
    assign op_chan.op    = q_reg[rd_ptr_reg];
    assign rd_en         = op_chan.valid && op_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= op_new;
        end
    end

endmodule

// File: src/bbc_back.sv
// Back end: stack engine with cached top of stack, stack RAM and a
// two-entry result queue. Depends on bbc_pkg and bbc_ram.
`timescale 1ns / 1ps

module bbc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bbc_pkg::op_chan_t op_chan,
    output logic              op_ready,
    output logic              empty,
    input  logic              pop,
    output bbc_pkg::out_t     result
);

    import bbc_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next, count_after;
    logic              error_reg, error_next, error_now;
    kind_t             top_reg, top_next;
    logic [CNT_W-1:0]  rd_index;
    logic [1:0]        ram_rdata;
    logic              take, do_push, do_pop, overflow, underflow, mismatch;
    out_t              res_new;

    out_t       rq_reg [2];
    logic       rq_wr_reg, rq_rd_reg;
    logic [1:0] rq_cnt_reg, rq_cnt_next;
    logic       rq_full, rq_pop;

    assign rq_full  = (rq_cnt_reg == 2'd2);
    assign op_ready = !rq_full;
    assign take     = op_chan.valid && !rq_full;

    always_comb
    begin
        do_push   = take && op_chan.op.is_open  && (count_reg <  CNT_W'(STACK_DEPTH));
        overflow  = take && op_chan.op.is_open  && (count_reg == CNT_W'(STACK_DEPTH));
        do_pop    = take && op_chan.op.is_close && (count_reg != '0);
        underflow = take && op_chan.op.is_close && (count_reg == '0);
        mismatch  = do_pop && (top_reg != op_chan.op.kind);
        error_now = error_reg || overflow || underflow || mismatch;

        count_after = count_reg;
        if (do_push)
        begin
            count_after = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_after = count_reg - CNT_W'(1);
        end

        res_new.done_res     = op_chan.op.last;
        res_new.balanced     = op_chan.op.last && !error_now && (count_after == '0);
        res_new.error_so_far = error_now;

        if (take && op_chan.op.last)
        begin
            count_next = '0;
            error_next = 1'b0;
        end
        else
        begin
            count_next = count_after;
            error_next = take ? error_now : error_reg;
        end

        // Refill the cached top from the entry just below it on a pop.
        top_next = top_reg;
        if (do_push)
        begin
            top_next = op_chan.op.kind;
        end
        else if (do_pop)
        begin
            top_next = kind_t'(ram_rdata);
        end

        // Prefetch the entry under next cycle's top.
        rd_index = count_next - CNT_W'(2);
    end

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (op_chan.op.kind),
        .raddr (rd_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            error_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            error_reg <= error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // Result queue.
    assign empty  = (rq_cnt_reg == 2'd0);
    assign rq_pop = pop && !empty;
    assign result = rq_reg[rq_rd_reg];
    assign rq_cnt_next = rq_cnt_reg + {1'b0, take} - {1'b0, rq_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            rq_wr_reg  <= rq_wr_reg ^ take;
            rq_rd_reg  <= rq_rd_reg ^ rq_pop;
            rq_cnt_reg <= rq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rq_reg[rq_wr_reg] <= res_new;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && op_chan.op.last |=> (count_reg == '0) && !error_reg)
        else $error("stack not cleared after last character");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg && !(take && op_chan.op.last) |=> error_reg)
        else $error("error flag dropped inside an expression");

    a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg <= 2'd2)
        else $error("result queue overrun");

endmodule

// File: src/bracket_balance_checker.sv
// Bracket balance checker top level: front classifier, stack engine.
// Depends on bbc_pkg, bbc_front, bbc_back (and bbc_ram through bbc_back).
//
//   channel   handshake         payload            direction
//   input     push / full       item   (in_t)      in
//   result    pop / empty       result (out_t)     out
//
// One character per cycle sustained while results are popped; every
// character yields one result. A character accepted waits in the front queue,
// passes the stack engine into the result queue, and can then be popped.
// The top of stack is cached in a register and the entry beneath it
// is prefetched from the stack RAM, so back-to-back pops run at full rate.
// Reset clears counts, pointers and the error flag; the stack RAM keeps its data.
// full rises when the front queue holds two requests; the engine stalls
// only when the result queue holds two unread results.
`timescale 1ns / 1ps

module bracket_balance_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  bbc_pkg::in_t  item,
    output logic          empty,
    input  logic          pop,
    output bbc_pkg::out_t result
);

    import bbc_pkg::*;

    op_chan_t op_chan;
    logic     op_ready;

    // Classify and buffer incoming characters.
    bbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .op_chan  (op_chan),
        .op_ready (op_ready)
    );

    // Run the stack and queue one result per request.
    bbc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_chan  (op_chan),
        .op_ready (op_ready),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule
